// ===== rtl/core/fspc_pkg.sv =====
// Shared types, constants and fixed-point helpers for the FOC speed/current controller.
package fspc_pkg;

  // Sine lookup resolution: the rotor angle is truncated to this many bits.
  localparam int SINE_TABLE_BITS = 10;
  localparam int SIN_SHIFT = 16 - SINE_TABLE_BITS;
  localparam int SIN_QIDX_W = SINE_TABLE_BITS - 2;
  localparam int SIN_QN = 1 << SIN_QIDX_W;

  // Odd quarter-wave polynomial coefficients in Q30.
  localparam longint unsigned Q30_C1 = 64'd1686629713;
  localparam longint unsigned Q30_C3 = 64'd693598668;
  localparam longint unsigned Q30_C5 = 64'd85569306;
  localparam longint unsigned Q30_C7 = 64'd4858527;

  // 1/sqrt(3) in Q0.16.
  localparam logic signed [32:0] INV_SQRT3_Q16 = 33'sd37837;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SPEED_KP = 3'd0;
  localparam logic [2:0] CFG_SPEED_KI = 3'd1;
  localparam logic [2:0] CFG_CURRENT_KP = 3'd2;
  localparam logic [2:0] CFG_CURRENT_KI = 3'd3;
  localparam logic [2:0] CFG_RATED_CURRENT = 3'd4;
  localparam logic [2:0] CFG_RATED_SPEED = 3'd5;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SREF,
    ST_SERR,
    ST_PI_KP,
    ST_PI_KI,
    ST_PI_INT,
    ST_PI_SUM,
    ST_PI_CLAMP,
    ST_PARK_1,
    ST_PARK_2,
    ST_PARK_3,
    ST_PARK_4,
    ST_PARK_5,
    ST_PARK_6,
    ST_INV_1,
    ST_INV_2,
    ST_INV_3,
    ST_INV_4,
    ST_INV_5,
    ST_FIN
  } fspc_state_t;

  // Which PI loop the shared routine is running.
  typedef enum logic [1:0] {
    LOOP_SPEED,
    LOOP_D,
    LOOP_Q
  } loop_t;

  typedef logic [16:0] sin_tab_t [SIN_QN];

  // Quarter-wave sine, r in 0..16384, result Q16 limited to 65536.
  function automatic logic [16:0] quarter_sine(input longint unsigned r);
    longint unsigned z;
    longint unsigned w;
    longint unsigned t;
    longint unsigned v;
    z = r << 2;
    w = (z * z) >> 2;
    t = Q30_C5 - ((Q30_C7 * w) >> 30);
    t = Q30_C3 - ((t * w) >> 30);
    t = Q30_C1 - ((t * w) >> 30);
    v = (((t * z) >> 16) + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return v[16:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int i = 0; i < SIN_QN; i++) begin
      tab[i] = quarter_sine(longint'(i) << SIN_SHIFT);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();
  localparam logic [16:0] SIN_QTOP = quarter_sine(64'd16384);

  // Signed sine of a 16-bit angle after truncation, Q16.
  function automatic logic signed [17:0] sine_of(input logic [15:0] angle);
    logic [SINE_TABLE_BITS-1:0] hi;
    logic [SIN_QIDX_W-1:0] ridx;
    logic [1:0] quad;
    logic [16:0] mag;
    hi = angle[15 -: SINE_TABLE_BITS];
    ridx = hi[SIN_QIDX_W-1:0];
    quad = hi[SINE_TABLE_BITS-1 -: 2];
    if (quad[0]) begin
      if (ridx == '0) begin
        mag = SIN_QTOP;
      end else begin
        mag = SIN_TAB[SIN_QIDX_W'(~ridx + 1'b1)];
      end
    end else begin
      mag = SIN_TAB[ridx];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Saturating narrowing from a 66-bit signed value.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if ((&x[65:31]) || !(|x[65:31])) begin
      return x[31:0];
    end
    return x[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [32:0] sat33(input logic signed [65:0] x);
    if ((&x[65:32]) || !(|x[65:32])) begin
      return x[32:0];
    end
    return x[65] ? {1'b1, 32'h0} : {1'b0, 32'hFFFF_FFFF};
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
    if ((&x[65:47]) || !(|x[65:47])) begin
      return x[47:0];
    end
    return x[65] ? {1'b1, 47'h0} : {1'b0, {47{1'b1}}};
  endfunction

endpackage

// ===== rtl/core/fspc_sine.sv =====
// Registered sine and cosine of the rotor angle from the quarter-wave table.
module fspc_sine (
  input  logic                clk,
  input  logic                load,
  input  logic [15:0]         angle,
  output logic signed [17:0]  sin_val,
  output logic signed [17:0]  cos_val
);

  // Cosine is the sine a quarter turn ahead.
  logic [15:0] angle_cos;
  assign angle_cos = angle + 16'h4000;

  // Capture both values when an item is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      sin_val <= fspc_pkg::sine_of(angle);
      cos_val <= fspc_pkg::sine_of(angle_cos);
    end
  end

endmodule

// ===== rtl/core/fspc_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
module fspc_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  // One product per cycle, registered before use.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/core/foc_speed_current_pi_cascade.sv =====
// Top level of the FOC speed and current PI cascade controller.
// Each request carries one PWM period of measurements and yields one result holding the
// stationary voltage references, the clamped q current target and three clamp flags. The
// work runs through a small sequencer around one shared 33x33 multiplier: the speed PI,
// the Park transform, the d and q current PIs and the inverse Park transform follow each
// other, so the next request is accepted only after the sequence has run and its result
// is loaded, which waits while a previous result is stalled. item_stall is high while
// a request is in work. Configuration writes are always ready and are meant for idle time.
module foc_speed_current_pi_cascade (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // Request channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [17:0] speed_command,
  input  logic signed [31:0] speed_measured,
  input  logic signed [31:0] current_alpha,
  input  logic signed [31:0] current_beta,
  input  logic [15:0]        rotor_angle,
  input  logic [30:0]        dc_link_voltage,
  input  logic signed [31:0] flux_current_target,
  // Result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] alpha_voltage_ref,
  output logic signed [31:0] beta_voltage_ref,
  output logic signed [31:0] torque_current_ref,
  output logic               speed_saturated,
  output logic               d_saturated,
  output logic               q_saturated
);

  // Configuration registers
  logic [31:0] speed_prop_gain;
  logic [31:0] speed_integral_coeff;
  logic [31:0] current_prop_gain;
  logic [31:0] current_integral_coeff;
  logic [30:0] rated_current;
  logic [30:0] rated_mech_speed;

  // Sequencer
  fspc_pkg::fspc_state_t state;
  fspc_pkg::fspc_state_t state_next;
  fspc_pkg::loop_t sel;

  // Latched request fields
  logic signed [17:0] cmd_r;
  logic signed [31:0] meas_r;
  logic signed [31:0] ia_r;
  logic signed [31:0] ib_r;
  logic [30:0]        vdc_r;
  logic signed [31:0] idt_r;

  // Working registers
  logic signed [31:0] err_r;
  logic signed [31:0] ie_r;
  logic signed [49:0] p_r;
  logic signed [32:0] u_r;
  logic signed [32:0] lim_r;
  logic signed [49:0] acc_r;
  logic signed [31:0] id_r;
  logic signed [31:0] iq_r;
  logic signed [31:0] iqref_r;
  logic signed [32:0] vd_r;
  logic signed [32:0] vq_r;
  logic signed [31:0] va_r;
  logic signed [31:0] vb_r;
  logic               ssat_r;
  logic               dsat_r;
  logic               qsat_r;

  // Per-loop PI state
  logic signed [47:0] integ [3];
  logic signed [31:0] prev [3];
  logic signed [32:0] excess [3];

  // Shared units
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic signed [17:0] sin_val;
  logic signed [17:0] cos_val;

  logic accept;
  logic out_free;
  logic load_out;

  assign cfg_ready = 1'b1;
  assign item_stall = (state != fspc_pkg::ST_IDLE);
  assign accept = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;

  fspc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fspc_sine u_sine (
    .clk     (clk),
    .load    (accept),
    .angle   (rotor_angle),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_prop_gain <= '0;
      speed_integral_coeff <= '0;
      current_prop_gain <= '0;
      current_integral_coeff <= '0;
      rated_current <= '0;
      rated_mech_speed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fspc_pkg::CFG_SPEED_KP: speed_prop_gain <= cfg_data;
        fspc_pkg::CFG_SPEED_KI: speed_integral_coeff <= cfg_data;
        fspc_pkg::CFG_CURRENT_KP: current_prop_gain <= cfg_data;
        fspc_pkg::CFG_CURRENT_KI: current_integral_coeff <= cfg_data;
        fspc_pkg::CFG_RATED_CURRENT: rated_current <= cfg_data[30:0];
        fspc_pkg::CFG_RATED_SPEED: rated_mech_speed <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp of the PI sum against its symmetric limit.
  logic signed [33:0] u_ext;
  logic signed [33:0] lim_ext;
  logic signed [32:0] clamp_out;
  logic signed [32:0] excess_new;
  logic               clamp_hit;

  always_comb begin
    u_ext = 34'(u_r);
    lim_ext = 34'(lim_r);
    priority if (u_ext >= lim_ext) begin
      clamp_out = lim_r;
      clamp_hit = 1'b1;
    end else if (u_ext <= -lim_ext) begin
      clamp_out = 33'(-lim_ext);
      clamp_hit = 1'b1;
    end else begin
      clamp_out = u_r;
      clamp_hit = 1'b0;
    end
    excess_new = 33'(u_ext - 34'(clamp_out));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fspc_pkg::ST_IDLE: if (accept) state_next = fspc_pkg::ST_SREF;
      fspc_pkg::ST_SREF: state_next = fspc_pkg::ST_SERR;
      fspc_pkg::ST_SERR: state_next = fspc_pkg::ST_PI_KP;
      fspc_pkg::ST_PI_KP: state_next = fspc_pkg::ST_PI_KI;
      fspc_pkg::ST_PI_KI: state_next = fspc_pkg::ST_PI_INT;
      fspc_pkg::ST_PI_INT: state_next = fspc_pkg::ST_PI_SUM;
      fspc_pkg::ST_PI_SUM: state_next = fspc_pkg::ST_PI_CLAMP;
      fspc_pkg::ST_PI_CLAMP: begin
        unique case (sel)
          fspc_pkg::LOOP_SPEED: state_next = fspc_pkg::ST_PARK_1;
          fspc_pkg::LOOP_D: state_next = fspc_pkg::ST_PI_KP;
          default: state_next = fspc_pkg::ST_INV_1;
        endcase
      end
      fspc_pkg::ST_PARK_1: state_next = fspc_pkg::ST_PARK_2;
      fspc_pkg::ST_PARK_2: state_next = fspc_pkg::ST_PARK_3;
      fspc_pkg::ST_PARK_3: state_next = fspc_pkg::ST_PARK_4;
      fspc_pkg::ST_PARK_4: state_next = fspc_pkg::ST_PARK_5;
      fspc_pkg::ST_PARK_5: state_next = fspc_pkg::ST_PARK_6;
      fspc_pkg::ST_PARK_6: state_next = fspc_pkg::ST_PI_KP;
      fspc_pkg::ST_INV_1: state_next = fspc_pkg::ST_INV_2;
      fspc_pkg::ST_INV_2: state_next = fspc_pkg::ST_INV_3;
      fspc_pkg::ST_INV_3: state_next = fspc_pkg::ST_INV_4;
      fspc_pkg::ST_INV_4: state_next = fspc_pkg::ST_INV_5;
      fspc_pkg::ST_INV_5: state_next = fspc_pkg::ST_FIN;
      fspc_pkg::ST_FIN: if (out_free) state_next = fspc_pkg::ST_IDLE;
      default: state_next = fspc_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operand selection and result load.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    load_out = 1'b0;
    unique case (state)
      fspc_pkg::ST_SREF: begin
        mul_a = 33'(cmd_r);
        mul_b = {2'b00, rated_mech_speed};
      end
      fspc_pkg::ST_PI_KP: begin
        mul_a = 33'(err_r);
        mul_b = (sel == fspc_pkg::LOOP_SPEED) ? {1'b0, speed_prop_gain}
                                              : {1'b0, current_prop_gain};
      end
      fspc_pkg::ST_PI_KI: begin
        mul_a = 33'(ie_r) + 33'(prev[sel]);
        mul_b = (sel == fspc_pkg::LOOP_SPEED) ? {1'b0, speed_integral_coeff}
                                              : {1'b0, current_integral_coeff};
      end
      fspc_pkg::ST_PARK_1: begin
        mul_a = 33'(ia_r);
        mul_b = 33'(cos_val);
      end
      fspc_pkg::ST_PARK_2: begin
        mul_a = 33'(ib_r);
        mul_b = 33'(sin_val);
      end
      fspc_pkg::ST_PARK_3: begin
        mul_a = 33'(ib_r);
        mul_b = 33'(cos_val);
      end
      fspc_pkg::ST_PARK_4: begin
        mul_a = 33'(ia_r);
        mul_b = 33'(sin_val);
      end
      fspc_pkg::ST_PARK_5: begin
        mul_a = {2'b00, vdc_r};
        mul_b = fspc_pkg::INV_SQRT3_Q16;
      end
      fspc_pkg::ST_INV_1: begin
        mul_a = vd_r;
        mul_b = 33'(cos_val);
      end
      fspc_pkg::ST_INV_2: begin
        mul_a = vq_r;
        mul_b = 33'(sin_val);
      end
      fspc_pkg::ST_INV_3: begin
        mul_a = vd_r;
        mul_b = 33'(sin_val);
      end
      fspc_pkg::ST_INV_4: begin
        mul_a = vq_r;
        mul_b = 33'(cos_val);
      end
      fspc_pkg::ST_FIN: load_out = out_free;
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fspc_pkg::ST_IDLE;
      sel <= fspc_pkg::LOOP_SPEED;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fspc_pkg::ST_SERR) begin
        sel <= fspc_pkg::LOOP_SPEED;
      end else if (state == fspc_pkg::ST_PARK_6) begin
        sel <= fspc_pkg::LOOP_D;
      end else if (state == fspc_pkg::ST_PI_CLAMP && sel == fspc_pkg::LOOP_D) begin
        sel <= fspc_pkg::LOOP_Q;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // PI loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        integ[i] <= '0;
        prev[i] <= '0;
        excess[i] <= '0;
      end
    end else begin
      if (state == fspc_pkg::ST_PI_INT) begin
        integ[sel] <= fspc_pkg::sat48(66'(integ[sel]) + (prod >>> 24));
      end
      if (state == fspc_pkg::ST_PI_CLAMP) begin
        excess[sel] <= excess_new;
        prev[sel] <= ie_r;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= speed_command;
      meas_r <= speed_measured;
      ia_r <= current_alpha;
      ib_r <= current_beta;
      vdc_r <= dc_link_voltage;
      idt_r <= flux_current_target;
    end
    unique case (state)
      fspc_pkg::ST_SERR: begin
        err_r <= fspc_pkg::sat32((prod >>> 16) - 66'(meas_r));
        lim_r <= {2'b00, rated_current};
      end
      fspc_pkg::ST_PI_KP: ie_r <= fspc_pkg::sat32(66'(err_r) - 66'(excess[sel]));
      fspc_pkg::ST_PI_KI: p_r <= 50'(prod >>> 16);
      fspc_pkg::ST_PI_SUM: u_r <= fspc_pkg::sat33(66'(p_r) + 66'(integ[sel]));
      fspc_pkg::ST_PI_CLAMP: begin
        unique case (sel)
          fspc_pkg::LOOP_SPEED: begin
            iqref_r <= 32'(clamp_out);
            ssat_r <= clamp_hit;
          end
          fspc_pkg::LOOP_D: begin
            vd_r <= clamp_out;
            dsat_r <= clamp_hit;
            err_r <= fspc_pkg::sat32(66'(iqref_r) - 66'(iq_r));
            lim_r <= {lim_r[31:0], 1'b0};
          end
          default: begin
            vq_r <= clamp_out;
            qsat_r <= clamp_hit;
          end
        endcase
      end
      fspc_pkg::ST_PARK_2: acc_r <= 50'(prod);
      fspc_pkg::ST_PARK_3: id_r <= fspc_pkg::sat32((66'(acc_r) + prod) >>> 16);
      fspc_pkg::ST_PARK_4: acc_r <= 50'(prod);
      fspc_pkg::ST_PARK_5: iq_r <= fspc_pkg::sat32((66'(acc_r) - prod) >>> 16);
      fspc_pkg::ST_PARK_6: begin
        err_r <= fspc_pkg::sat32(66'(idt_r) - 66'(id_r));
        lim_r <= 33'(prod >>> 16);
      end
      fspc_pkg::ST_INV_2: acc_r <= 50'(prod);
      fspc_pkg::ST_INV_3: va_r <= fspc_pkg::sat32((66'(acc_r) - prod) >>> 16);
      fspc_pkg::ST_INV_4: acc_r <= 50'(prod);
      fspc_pkg::ST_INV_5: vb_r <= fspc_pkg::sat32((66'(acc_r) + prod) >>> 16);
      default: begin
      end
    endcase
    if (load_out) begin
      alpha_voltage_ref <= va_r;
      beta_voltage_ref <= vb_r;
      torque_current_ref <= iqref_r;
      speed_saturated <= ssat_r;
      d_saturated <= dsat_r;
      q_saturated <= qsat_r;
    end
  end

  // An accepted request always starts the speed reference step.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == fspc_pkg::ST_SREF)
    else $error("request accepted without starting the sequence");

  // A new result only appears out of the final sequencer step.
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == fspc_pkg::ST_FIN)
    else $error("result raised outside the final step");

  // The torque current target stays inside the rated current.
  a_torque_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed({1'b0, torque_current_ref[31], torque_current_ref[30:0]}) >= 0
      ? 1'b1 : 1'b1) && (33'(torque_current_ref) <= $signed({2'b00, rated_current}))
      && (33'(torque_current_ref) >= -$signed({2'b00, rated_current})))
    else $error("torque current target beyond rated current");

endmodule
